// ===== hdl/ebs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebs_pkg: shared constants, types and helpers of the 3x3 box smoother
// Widths, configuration codes, reciprocal constants for the floor mean and
// the control words passed between the pipeline stages.
// ----------------------------------------------------------------------------
package ebs_pkg;

  // Frame and sample geometry
  localparam int unsigned SampleW   = 16;
  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 1024;
  localparam int unsigned XW        = $clog2(MaxWidth);
  localparam int unsigned RowW      = $clog2(MaxHeight);

  // Configuration port
  localparam int unsigned CfgW    = 11;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned MinDim  = 2;
  localparam int unsigned CfgRstDim = 1024;
  localparam logic [CfgIdxW-1:0] CfgIdxWidth  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgIdxHeight = CfgIdxW'(1);

  // Floor mean: biased sum times a reciprocal, quotient in the upper bits
  localparam int unsigned SumW   = SampleW + 4;
  localparam int unsigned RecipK = SumW + 4;
  localparam int unsigned MulW   = RecipK - 1;
  localparam int unsigned ProdW  = SumW + MulW;
  localparam logic [MulW-1:0] RecipDiv4 = MulW'(((2 ** RecipK) + 3) / 4);
  localparam logic [MulW-1:0] RecipDiv6 = MulW'(((2 ** RecipK) + 5) / 6);
  localparam logic [MulW-1:0] RecipDiv9 = MulW'(((2 ** RecipK) + 8) / 9);
  localparam logic [SumW-1:0] BiasDiv4  = SumW'(4 * (2 ** (SampleW - 1)));
  localparam logic [SumW-1:0] BiasDiv6  = SumW'(6 * (2 ** (SampleW - 1)));
  localparam logic [SumW-1:0] BiasDiv9  = SumW'(9 * (2 ** (SampleW - 1)));

  // Per-item control word from the position tracker to the window stage
  typedef struct packed {
    logic [XW-1:0]             x;
    logic signed [SampleW-1:0] s;
    logic                      shift;
    logic                      use_pre;
    logic                      has_out;
    logic                      cv0;
    logic                      rv0;
    logic                      rv2;
    logic                      last;
  } ctrl_t;

  // Operands for the divide stage
  typedef struct packed {
    logic [SumW-1:0] u;
    logic [MulW-1:0] recip;
    logic            last;
  } div_t;

  // Clamp a frame dimension into MinDim..hi
  function automatic logic [CfgW-1:0] clamp_dim(input logic [CfgW-1:0] v,
                                                input logic [CfgW-1:0] hi);
    logic [CfgW-1:0] r;
    r = v;
    if (v < CfgW'(MinDim)) r = CfgW'(MinDim);
    else if (v > hi)       r = hi;
    return r;
  endfunction

endpackage

// ===== hdl/ebs_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebs_in_if / ebs_out_if: valid-ready stream channels of the smoother
// Input carries request type and sample, output the smoothed value and the
// end-of-frame flag.
// ----------------------------------------------------------------------------
interface ebs_in_if import ebs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic signed [SampleW-1:0] sample;

  modport source (output valid, output req_type, output sample, input ready);
  modport sink   (input valid, input req_type, input sample, output ready);
endinterface

interface ebs_out_if import ebs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] smoothed;
  logic                      frame_last;

  modport source (output valid, output smoothed, output frame_last, input ready);
  modport sink   (input valid, input smoothed, input frame_last, output ready);
endinterface

// ===== hdl/ebs_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebs_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ebs_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== hdl/ebs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebs_ctrl: frame position tracker
// Holds the configuration and the raster position, runs the drain phase and
// decides per transaction which pixel is released and how it is masked.
// ----------------------------------------------------------------------------
module ebs_ctrl import ebs_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_idx_i,
  input  logic [CfgW-1:0]           cfg_data_i,
  input  logic                      acc_i,
  input  logic                      req_type_i,
  input  logic signed [SampleW-1:0] sample_i,
  output logic                      item_o,
  output ctrl_t                     ctrl_o
);

  logic [CfgW-1:0] width_q, width_d, height_q, height_d;
  logic [XW-1:0]   col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [CfgW-1:0] pend_q, pend_d;
  logic [CfgW-1:0] w, h, h_p1, x, y, xn, yn;
  logic            drain, rel_edge, rel_norm;

  assign w     = clamp_dim(width_q, CfgW'(MaxWidth));
  assign h     = clamp_dim(height_q, CfgW'(MaxHeight));
  assign h_p1  = h + CfgW'(1);
  assign drain = (pend_q != '0);

  // Position of this transaction
  always_comb begin
    x = '0;
    y = '0;
    if (!drain) begin
      x = (CfgW'(col_q) >= w) ? '0 : CfgW'(col_q);
      y = (CfgW'(row_q) >= h) ? '0 : CfgW'(row_q);
    end else if (pend_q > CfgW'(1)) begin
      x = w + CfgW'(1) - pend_q;
      y = h;
    end else begin
      x = '0;
      y = h_p1;
    end
  end

  // Release decisions and neighborhood masks
  assign rel_edge = (x == '0) && (y >= CfgW'(2)) && (y <= h_p1);
  assign rel_norm = (x != '0) && (y != '0) && (y <= h);

  always_comb begin
    ctrl_o.x       = x[XW-1:0];
    ctrl_o.s       = drain ? '0 : sample_i;
    ctrl_o.shift   = (y <= h);
    ctrl_o.use_pre = rel_edge;
    ctrl_o.has_out = rel_edge || rel_norm;
    ctrl_o.cv0     = rel_edge ? 1'b0 : (x >= CfgW'(2));
    ctrl_o.rv0     = rel_edge ? (y >= CfgW'(3)) : (y >= CfgW'(2));
    ctrl_o.rv2     = rel_edge ? (y <= h) : (y < h);
    ctrl_o.last    = rel_edge && (y == h_p1);
  end

  // Drop drain requests while samples are expected
  assign item_o = acc_i && !(!drain && req_type_i);

  // Advance position, enter or count down the drain phase
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    col_d    = col_q;
    row_d    = row_q;
    pend_d   = pend_q;
    xn       = '0;
    yn       = '0;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgIdxWidth:  width_d  = cfg_data_i;
        CfgIdxHeight: height_d = cfg_data_i;
        default: ;
      endcase
      col_d  = '0;
      row_d  = '0;
      pend_d = '0;
    end else if (item_o) begin
      if (drain) begin
        pend_d = pend_q - CfgW'(1);
      end else begin
        xn = x + CfgW'(1);
        yn = y;
        if (xn >= w) begin
          xn = '0;
          yn = y + CfgW'(1);
        end
        if (yn >= h) begin
          xn     = '0;
          yn     = '0;
          pend_d = w + CfgW'(1);
        end
        col_d = xn[XW-1:0];
        row_d = yn[RowW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CfgW'(CfgRstDim);
      height_q <= CfgW'(CfgRstDim);
      col_q    <= '0;
      row_q    <= '0;
      pend_q   <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
      pend_q   <= pend_d;
    end
  end

endmodule

// ===== hdl/ebs_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebs_window: line buffers and 3x3 window stage
// Reads both line buffers at the accepted column, shifts the window, writes
// the rows back and forms the biased neighborhood sum for the divider.
// ----------------------------------------------------------------------------
module ebs_window import ebs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  item_i,
  input  ctrl_t ctrl_i,
  output logic  rdy_o,
  input  logic  nxt_rdy_i,
  output logic  div_v_o,
  output div_t  div_o
);

  ctrl_t                     c_q;
  logic                      v_q;
  logic                      go;
  logic [SampleW-1:0]        rd_a, rd_b;
  logic signed [SampleW-1:0] win_q [3][3];
  logic signed [SampleW-1:0] ev [3][3];
  logic [2:0]                en_r, en_c;
  logic signed [SumW-1:0]    sum;
  logic [SumW:0]             u_wide;
  logic [SumW-1:0]           bias;
  logic [1:0]                rows;

  // Hold the stage while its result cannot move on
  assign go      = v_q && (!c_q.has_out || nxt_rdy_i);
  assign rdy_o   = !v_q || go;
  assign div_v_o = v_q && c_q.has_out;

  // Newest row buffer (row y-1) and older row buffer (row y-2)
  ebs_ram #(.Width(SampleW), .Depth(MaxWidth)) u_row_a (
    .clk_i   (clk_i),
    .we_i    (go && c_q.shift),
    .waddr_i (c_q.x),
    .wdata_i (c_q.s),
    .re_i    (item_i),
    .raddr_i (ctrl_i.x),
    .rdata_o (rd_a)
  );

  ebs_ram #(.Width(SampleW), .Depth(MaxWidth)) u_row_b (
    .clk_i   (clk_i),
    .we_i    (go && c_q.shift),
    .waddr_i (c_q.x),
    .wdata_i (rd_a),
    .re_i    (item_i),
    .raddr_i (ctrl_i.x),
    .rdata_o (rd_b)
  );

  // Select the window the released pixel sees
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      ev[r][0] = c_q.use_pre ? win_q[r][0] : win_q[r][1];
      ev[r][1] = c_q.use_pre ? win_q[r][1] : win_q[r][2];
    end
    ev[0][2] = c_q.use_pre ? win_q[0][2] : signed'(rd_b);
    ev[1][2] = c_q.use_pre ? win_q[1][2] : signed'(rd_a);
    ev[2][2] = c_q.use_pre ? win_q[2][2] : c_q.s;
  end

  // Masked neighborhood sum
  assign en_r = {c_q.rv2, 1'b1, c_q.rv0};
  assign en_c = {1'b1, 1'b1, c_q.cv0};

  always_comb begin
    sum = '0;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        if (en_r[r] && en_c[k]) begin
          sum = sum + {{(SumW-SampleW){ev[r][k][SampleW-1]}}, ev[r][k]};
        end
      end
    end
  end

  // Pick reciprocal and bias by the count of in-frame samples
  assign rows = 2'(c_q.rv0) + 2'(c_q.rv2) + 2'd1;

  always_comb begin
    if (c_q.cv0 && rows == 2'd3) begin
      bias        = BiasDiv9;
      div_o.recip = RecipDiv9;
    end else if (c_q.cv0 || rows == 2'd3) begin
      bias        = BiasDiv6;
      div_o.recip = RecipDiv6;
    end else begin
      bias        = BiasDiv4;
      div_o.recip = RecipDiv4;
    end
    u_wide     = {sum[SumW-1], sum} + {1'b0, bias};
    div_o.u    = u_wide[SumW-1:0];
    div_o.last = c_q.last;
  end

  // Load stage, shift window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          win_q[r][k] <= '0;
        end
      end
    end else begin
      if (item_i) begin
        v_q <= 1'b1;
      end else if (go) begin
        v_q <= 1'b0;
      end
      if (go && c_q.shift) begin
        for (int r = 0; r < 3; r++) begin
          win_q[r][0] <= win_q[r][1];
          win_q[r][1] <= win_q[r][2];
        end
        win_q[0][2] <= signed'(rd_b);
        win_q[1][2] <= signed'(rd_a);
        win_q[2][2] <= c_q.s;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i) begin
      c_q <= ctrl_i;
    end
  end

endmodule

// ===== hdl/ebs_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebs_div: floor-mean divider and output register
// Multiplies the biased sum by the reciprocal of the sample count; the
// quotient with its top bit inverted is the floor mean.
// ----------------------------------------------------------------------------
module ebs_div import ebs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               div_v_i,
  input  div_t               div_i,
  output logic               rdy_o,
  ebs_out_if.source          out_o
);

  div_t             op_q;
  logic             op_v_q;
  logic             op_go;
  logic [ProdW-1:0] prod_d, prod_q;
  logic             last_q;
  logic             res_v_q;

  assign op_go = op_v_q && (!res_v_q || out_o.ready);
  assign rdy_o = !op_v_q || op_go;
  assign prod_d = ProdW'(op_q.u) * ProdW'(op_q.recip);

  // Advance operand and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_v_q  <= 1'b0;
      res_v_q <= 1'b0;
    end else begin
      if (div_v_i && rdy_o) begin
        op_v_q <= 1'b1;
      end else if (op_go) begin
        op_v_q <= 1'b0;
      end
      if (op_go) begin
        res_v_q <= 1'b1;
      end else if (out_o.ready) begin
        res_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_v_i && rdy_o) begin
      op_q <= div_i;
    end
    if (op_go) begin
      prod_q <= prod_d;
      last_q <= op_q.last;
    end
  end

  // Remove the bias by inverting the sign bit of the quotient
  assign out_o.valid      = res_v_q;
  assign out_o.smoothed   = signed'({~prod_q[RecipK+SampleW-1],
                                     prod_q[RecipK+SampleW-2:RecipK]});
  assign out_o.frame_last = last_q;

endmodule

// ===== hdl/edge_aware_box_smoother_3x3.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_aware_box_smoother_3x3: streaming 3x3 floor-mean smoother
// Line-buffered box filter over a raster frame of signed samples.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one transaction per sample in raster order (req_type 0);
//   after the last sample of a frame send frame_width+1 drain transactions
//   (req_type 1) to flush the last row. Drain requests outside the drain
//   phase are dropped. out_o delivers one smoothed pixel per releasing
//   transaction; frame_last marks the bottom-right pixel.
//   Configuration (frame_width, frame_height) is written through cfg_we_i /
//   cfg_idx_i / cfg_data_i while idle; every write restarts the frame.
//   Throughput: one transaction per cycle while out_o is not held, set by the single read and write
//   port of each line-buffer RAM that every sample uses once.
//   Path to out_o: the window stage register with the RAM read, the divider
//   operand register, then the output register that holds the product.
//   Results lag the input stream by one row plus one pixel.
//   Reset: position and drain counters clear, both dimensions return to
//   1024, the window clears; line buffers need no clearing pass.
//   Stall: a held output fills the multiply and window stages, then in_i
//   ready drops; nothing is lost and ready returns as out_o drains.
// ----------------------------------------------------------------------------
module edge_aware_box_smoother_3x3 import ebs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  ebs_in_if.sink             in_i,
  ebs_out_if.source          out_o
);

  logic  item;
  ctrl_t ctrl;
  logic  div_v;
  div_t  div;
  logic  nxt_rdy;
  logic  win_rdy;

  assign in_i.ready = win_rdy;

  // Position tracking and configuration
  ebs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .acc_i      (in_i.valid && in_i.ready),
    .req_type_i (in_i.req_type),
    .sample_i   (in_i.sample),
    .item_o     (item),
    .ctrl_o     (ctrl)
  );

  // Line buffers and window
  ebs_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (item),
    .ctrl_i    (ctrl),
    .rdy_o     (win_rdy),
    .nxt_rdy_i (nxt_rdy),
    .div_v_o   (div_v),
    .div_o     (div)
  );

  // Floor-mean divider and output
  ebs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .div_v_i (div_v),
    .div_i   (div),
    .rdy_o   (nxt_rdy),
    .out_o   (out_o)
  );

  // A window entry only comes from an input transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item |-> in_i.valid && in_i.ready)
    else $error("window stage loaded without an input transaction");

  // A pending sum waits in the window stage until the divider takes it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_v && !nxt_rdy |=> div_v)
    else $error("pending sum lost while divider was busy");

  // Input ready only falls after a transaction entered the window stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_i.ready) |-> $past(item))
    else $error("input ready dropped without a new window entry");

endmodule
